>>> src/shps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shps_pkg: shared types and constants
// Widths, the hash seed, configuration register indexes and the small
// structs that pass control and status between the hash probe slot modules.
// ----------------------------------------------------------------------------
package shps_pkg;

  localparam int HASH_W    = 64;
  localparam int BYTE_W    = 8;
  localparam int SIZE_W    = 16;
  localparam int PROBE_W   = 16;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;
  localparam int CNT_W     = $clog2(HASH_W);
  localparam int PROD_W    = 33;

  localparam logic [HASH_W-1:0] HASH_SEED    = 64'd5381;
  localparam logic [SIZE_W-1:0] SIZE_RESET   = 16'd1024;
  localparam logic [SIZE_W-1:0] SIZE_MIN     = 16'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_MODE = 8'd1;

  localparam logic MODE_LINEAR = 1'b0;
  localparam logic MODE_DOUBLE = 1'b1;

  typedef struct packed {
    logic fold;
    logic reload;
  } hash_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> src/shps_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shps_if: handshake channels of the hash probe slot unit
// Key byte channel, slot result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface shps_key_if
  import shps_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  key_byte;
  logic               last_byte;
  logic [PROBE_W-1:0] probe_number;

  modport source (output valid, key_byte, last_byte, probe_number, input ready);
  modport sink   (input valid, key_byte, last_byte, probe_number, output ready);
endinterface

interface shps_slot_if
  import shps_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] slot_index;

  modport source (output valid, slot_index, input ready);
  modport sink   (input valid, slot_index, output ready);
endinterface

interface shps_cfg_if
  import shps_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/shps_hash_acc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shps_hash_acc: djb2 accumulator
// Folds one nonzero key byte per cycle while ctl.fold is set, as hash*33+byte modulo 2^64,
// and reloads the seed once a key has been handed off.
// ----------------------------------------------------------------------------
module shps_hash_acc
  import shps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  hash_ctl_t         ctl,
  input  logic [BYTE_W-1:0] key_byte,
  output logic [HASH_W-1:0] acc
);

  logic [HASH_W-1:0] acc_next;

  always_comb begin
    acc_next = acc;
    if (ctl.reload) begin
      acc_next = HASH_SEED;
    end else if (ctl.fold && (key_byte != '0)) begin
      acc_next = (acc << 5) + acc + HASH_W'(key_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= HASH_SEED;
    end else begin
      acc <= acc_next;
    end
  end

endmodule

>>> src/shps_serial_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shps_serial_mod: bit-serial dual remainder unit
// Shifts a 64-bit dividend out one bit per cycle, most significant first,
// and keeps two restoring remainders against two moduli at once.
// ----------------------------------------------------------------------------
module shps_serial_mod
  import shps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [HASH_W-1:0] dividend,
  input  logic [SIZE_W-1:0] mod_a,
  input  logic [SIZE_W-1:0] mod_b,
  output div_stat_t         stat,
  output logic [SIZE_W-1:0] rem_a,
  output logic [SIZE_W-1:0] rem_b
);

  logic [HASH_W-1:0] shreg;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;
  logic [SIZE_W:0]   ra_sh;
  logic [SIZE_W:0]   rb_sh;
  logic [SIZE_W:0]   ra_next;
  logic [SIZE_W:0]   rb_next;

  // Each remainder stays below its modulus, so the shifted value is below
  // twice the modulus and one conditional subtract reduces it.
  always_comb begin
    ra_sh   = {rem_a, shreg[HASH_W-1]};
    rb_sh   = {rem_b, shreg[HASH_W-1]};
    ra_next = (ra_sh >= {1'b0, mod_a}) ? ra_sh - {1'b0, mod_a} : ra_sh;
    rb_next = (rb_sh >= {1'b0, mod_b}) ? rb_sh - {1'b0, mod_b} : rb_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(HASH_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem_a <= '0;
      rem_b <= '0;
    end else if (busy) begin
      shreg <= shreg << 1;
      rem_a <= ra_next[SIZE_W-1:0];
      rem_b <= rb_next[SIZE_W-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

>>> src/string_hash_probe_slot_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_hash_probe_slot_unit: djb2 key hash to probe table slot
// Hashes keys byte by byte and returns a table slot for a probe number,
// by linear probing or double hashing.
// ----------------------------------------------------------------------------
// Usage:
//   key  : one key byte per item with last_byte and probe_number. A byte of
//          zero is skipped. A byte that is not last leaves key.ready high.
//   slot : one slot_index item for every item marked last_byte.
//   cfg  : index 0 writes table_size (below 3 acts as 3), index 1 writes
//          probe_mode. Other indexes are ignored. Always ready; write only
//          while no key is in progress.
// A last byte holds key.ready low while a bit-serial remainder unit
// runs its passes. Linear mode needs one pass, double hashing two
// passes plus a multiply. The serial pass sets the throughput on short
// keys. The result sits in an output register; while the receiver stalls
// the next key is still hashed, and a following last byte waits for the
// register to empty before its slot is written.
// Reset: synchronous; the accumulator reloads 5381, table_size 1024,
// probe_mode linear, the output register is emptied.
// ----------------------------------------------------------------------------
module string_hash_probe_slot_unit
  import shps_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  shps_key_if.sink    key,
  shps_slot_if.source slot,
  shps_cfg_if.sink    cfg
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LOAD = 7'b0000010,
    S_DIV1 = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_SUM  = 7'b0010000,
    S_DIV2 = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [SIZE_W-1:0]  table_size;
  logic               probe_mode;
  logic [SIZE_W-1:0]  eff_size;
  logic [SIZE_W-1:0]  eff_size_m2;
  logic [PROBE_W-1:0] probe;
  logic [SIZE_W-1:0]  rem_h;
  logic [PROD_W-1:0]  prod;
  logic [SIZE_W-1:0]  out_slot;
  logic               out_valid;
  logic               key_acc;
  logic               out_load;
  hash_ctl_t          hash_ctl;
  div_stat_t          div_stat;
  logic               div_start;
  logic [HASH_W-1:0]  div_dividend;
  logic [HASH_W-1:0]  acc;
  logic [SIZE_W-1:0]  rem_a;
  logic [SIZE_W-1:0]  rem_b;

  assign eff_size    = (table_size < SIZE_MIN) ? SIZE_MIN : table_size;
  assign eff_size_m2 = eff_size - SIZE_W'(2);

  assign key.ready  = (state == S_IDLE);
  assign key_acc    = key.valid && key.ready;
  assign cfg.ready  = 1'b1;
  assign slot.valid = out_valid;
  assign slot.slot_index = out_slot;

  assign hash_ctl.fold   = key_acc;
  assign hash_ctl.reload = (state == S_LOAD);

  assign out_load = (state == S_OUT) && (!out_valid || slot.ready);

  shps_hash_acc u_hash (
    .clk      (clk),
    .rst      (rst),
    .ctl      (hash_ctl),
    .key_byte (key.key_byte),
    .acc      (acc)
  );

  // The first pass works on the hash itself in double hashing mode, or on
  // the wrapped sum hash+probe in linear mode. The second pass reduces the
  // double hashing sum, which stays below 2^33.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = HASH_W'(rem_h) + HASH_W'(prod);
    if (state == S_LOAD) begin
      div_start    = 1'b1;
      div_dividend = (probe_mode == MODE_DOUBLE) ? acc : acc + HASH_W'(probe);
    end else if (state == S_SUM) begin
      div_start = 1'b1;
    end
  end

  shps_serial_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .mod_a    (eff_size),
    .mod_b    (eff_size_m2),
    .stat     (div_stat),
    .rem_a    (rem_a),
    .rem_b    (rem_b)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (key_acc && key.last_byte) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        state_next = (probe_mode == MODE_DOUBLE) ? S_DIV1 : S_DIV2;
      end
      S_DIV1: begin
        if (div_stat.done) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        state_next = S_SUM;
      end
      S_SUM: begin
        state_next = S_DIV2;
      end
      S_DIV2: begin
        if (div_stat.done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      table_size <= SIZE_RESET;
      probe_mode <= MODE_LINEAR;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          CFG_TABLE_SIZE: table_size <= cfg.data[SIZE_W-1:0];
          CFG_PROBE_MODE: probe_mode <= cfg.data[0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (slot.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (key_acc && key.last_byte) begin
      probe <= key.probe_number;
    end
    if (state == S_MUL) begin
      rem_h <= rem_a;
      prod  <= PROD_W'(probe) * PROD_W'({1'b0, rem_b} + 17'd1);
    end
    if (out_load) begin
      out_slot <= rem_a;
    end
  end

endmodule

>>> src/shps_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shps_chk: port-level checks for the hash probe slot unit
// Watches the channels of the top level and is bound to it.
// ----------------------------------------------------------------------------
module shps_chk
  import shps_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 key_valid,
  input logic                 key_ready,
  input logic                 key_last,
  input logic                 slot_valid,
  input logic                 slot_ready,
  input logic [SIZE_W-1:0]    slot_index,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [CFG_DAT_W-1:0] cfg_data
);

  logic [SIZE_W-1:0] size_shadow;
  logic [SIZE_W-1:0] size_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_shadow <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready && (cfg_index == CFG_TABLE_SIZE)) begin
      size_shadow <= cfg_data[SIZE_W-1:0];
    end
  end

  assign size_eff = (size_shadow < SIZE_MIN) ? SIZE_MIN : size_shadow;

  a_slot_hold: assert property (@(posedge clk) disable iff (rst)
    (slot_valid && !slot_ready) |=> (slot_valid && $stable(slot_index)))
    else $error("slot item dropped or changed while stalled");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot_valid |-> (slot_index < size_eff))
    else $error("slot index outside the table");

  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    (key_valid && key_ready && key_last) |=> !key_ready)
    else $error("key accepted while a slot is being computed");

  a_slot_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(slot_valid) |-> $past(!key_ready))
    else $error("slot item appeared without a pending key");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !slot_valid)
    else $error("slot item present after reset");

endmodule

bind string_hash_probe_slot_unit shps_chk u_shps_chk (
  .clk        (clk),
  .rst        (rst),
  .key_valid  (key.valid),
  .key_ready  (key.ready),
  .key_last   (key.last_byte),
  .slot_valid (slot.valid),
  .slot_ready (slot.ready),
  .slot_index (slot.slot_index),
  .cfg_valid  (cfg.valid),
  .cfg_ready  (cfg.ready),
  .cfg_index  (cfg.index),
  .cfg_data   (cfg.data)
);
